// File: design/tspm_pkg.sv
`default_nettype none
// ============================================================================
// tspm_pkg
// Types, constants and helpers shared by the touch sample to pixel mapper.
// ============================================================================
package tspm_pkg;

    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;

    localparam int SMP_W   = 12;
    localparam int PRS_W   = SMP_W + 1;
    localparam int PIX_W   = 9;
    localparam int CIDX_W  = 4;
    localparam int CDAT_W  = 32;
    localparam int COEF_W  = 32;
    localparam int DEN_W   = 31;
    localparam int OFS_W   = 8;
    localparam int MULB_W  = 14;
    localparam int NUM_W   = COEF_W + MULB_W;
    localparam int MAG_W   = NUM_W - 1;
    localparam int Q_W     = 13;
    localparam int SUM_W   = Q_W + 2;
    localparam int AX_N    = 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // pop -> product, sum, magnitude, divider (Q_W + 1), output register
    localparam int SIDE_LEN   = Q_W + 4;
    localparam int RESULT_LAT = Q_W + 6;

    localparam logic [SMP_W-1:0] RAWX_LO   = 12'd28;
    localparam logic [SMP_W-1:0] RAWX_HI   = 12'd1800;
    localparam logic [SMP_W-1:0] RAWY_LO   = 12'd300;
    localparam logic [SMP_W-1:0] RAWY_HI   = 12'd2047;
    localparam logic [PRS_W-1:0] PRESS_LIMIT = 13'd200;
    localparam logic [SMP_W-1:0] PRESS_MAX   = 12'd4095;

    localparam logic [DEN_W-1:0] FB_DEN_X = DEN_W'(RAWY_HI - RAWY_LO);
    localparam logic [DEN_W-1:0] FB_DEN_Y = DEN_W'(RAWX_HI - RAWX_LO);

    typedef enum logic [CIDX_W-1:0] {
        CFG_CAL_VALID = 4'd0,
        CFG_ALPHA_X   = 4'd1,
        CFG_BETA_X    = 4'd2,
        CFG_ALPHA_Y   = 4'd3,
        CFG_BETA_Y    = 4'd4,
        CFG_DIVIDER   = 4'd5,
        CFG_TRIM_X    = 4'd6,
        CFG_TRIM_Y    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SMP_W-1:0] press_a;
        logic [SMP_W-1:0] press_b;
        logic [SMP_W-1:0] x_sample_0;
        logic [SMP_W-1:0] x_sample_1;
        logic [SMP_W-1:0] x_sample_2;
        logic [SMP_W-1:0] x_sample_3;
        logic [SMP_W-1:0] y_sample_0;
        logic [SMP_W-1:0] y_sample_1;
        logic [SMP_W-1:0] y_sample_2;
        logic [SMP_W-1:0] y_sample_3;
    } t_touch_frame;

    typedef struct packed {
        logic             touched;
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [SMP_W-1:0] pressure;
    } t_touch_result;

    typedef struct packed {
        logic                     cal_valid;
        logic signed [COEF_W-1:0] alpha_x;
        logic signed [COEF_W-1:0] beta_x;
        logic signed [COEF_W-1:0] alpha_y;
        logic signed [COEF_W-1:0] beta_y;
        logic        [DEN_W-1:0]  divider;
        logic signed [OFS_W-1:0]  trim_x;
        logic signed [OFS_W-1:0]  trim_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cal_valid: 1'b0,
        alpha_x:   '0,
        beta_x:    '0,
        alpha_y:   '0,
        beta_y:    '0,
        divider:   DEN_W'(1),
        trim_x:    OFS_W'(30),
        trim_y:    '0
    };

    // one axis: (mul_a * mul_b + addend) / den
    typedef struct packed {
        logic signed [COEF_W-1:0] mul_a;
        logic signed [MULB_W-1:0] mul_b;
        logic signed [COEF_W-1:0] addend;
        logic        [DEN_W-1:0]  den;
    } t_axis_op;

    typedef struct packed {
        logic             touched;
        logic [SMP_W-1:0] pressure;
        t_axis_op         ax;
        t_axis_op         ay;
    } t_work;

    typedef struct packed {
        logic             touched;
        logic [SMP_W-1:0] pressure;
    } t_side;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [SMP_W-1:0] clamp_smp(input logic [SMP_W-1:0] v,
                                                   input logic [SMP_W-1:0] lo,
                                                   input logic [SMP_W-1:0] hi);
        logic [SMP_W-1:0] c;
        if (v < lo) begin
            c = lo;
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] to_pixel(input logic signed [SUM_W-1:0] v,
                                                  input logic signed [SUM_W-1:0] size);
        logic signed [SUM_W-1:0] c;
        if (v < 0) begin
            c = '0;
        end else if (v >= size) begin
            c = size - SUM_W'(1);
        end else begin
            c = v;
        end
        return c[PIX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: design/tspm_front.sv
`default_nettype none
// ============================================================================
// tspm_front
// Takes a frame, derives pressure and averages, and sets up both axis jobs.
// ============================================================================
module tspm_front import tspm_pkg::*; (
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire t_touch_frame i_frame,
    input  wire t_cfg         i_cfg,
    input  wire t_fifo_stat   i_fifo_stat,
    output logic              o_busy,
    output logic              o_push,
    output t_work             o_item
);

    logic [PRS_W-1:0]   press;
    logic [SMP_W+1:0]   sum_x;
    logic [SMP_W+1:0]   sum_y;
    logic [SMP_W-1:0]   avg_x;
    logic [SMP_W-1:0]   avg_y;
    logic [SMP_W-1:0]   cx;
    logic [SMP_W-1:0]   cy;
    logic [DEN_W-1:0]   den;

    assign o_busy = !i_rst_n || i_fifo_stat.full;
    assign o_push = i_start && !o_busy;

    // a - b + 4096, never below 1
    assign press = {1'b1, i_frame.press_a} - PRS_W'(i_frame.press_b);

    assign sum_x = (SMP_W+2)'(i_frame.x_sample_0) + (SMP_W+2)'(i_frame.x_sample_1)
                 + (SMP_W+2)'(i_frame.x_sample_2) + (SMP_W+2)'(i_frame.x_sample_3);
    assign sum_y = (SMP_W+2)'(i_frame.y_sample_0) + (SMP_W+2)'(i_frame.y_sample_1)
                 + (SMP_W+2)'(i_frame.y_sample_2) + (SMP_W+2)'(i_frame.y_sample_3);
    assign avg_x = sum_x[SMP_W+1:2];
    assign avg_y = sum_y[SMP_W+1:2];

    assign cx  = clamp_smp(avg_x, RAWX_LO, RAWX_HI);
    assign cy  = clamp_smp(avg_y, RAWY_LO, RAWY_HI);
    assign den = (i_cfg.divider == '0) ? DEN_W'(1) : i_cfg.divider;

    always_comb begin
        o_item.touched  = (press >= PRESS_LIMIT);
        o_item.pressure = (press > PRS_W'(PRESS_MAX)) ? PRESS_MAX : press[SMP_W-1:0];
        if (i_cfg.cal_valid) begin
            o_item.ax.mul_a  = i_cfg.alpha_x;
            o_item.ax.mul_b  = MULB_W'(avg_x);
            o_item.ax.addend = i_cfg.beta_x;
            o_item.ax.den    = den;
            o_item.ay.mul_a  = i_cfg.alpha_y;
            o_item.ay.mul_b  = MULB_W'(avg_y);
            o_item.ay.addend = i_cfg.beta_y;
            o_item.ay.den    = den;
        end else begin
            // fallback swaps axes
            o_item.ax.mul_a  = COEF_W'(cy - RAWY_LO);
            o_item.ax.mul_b  = MULB_W'(SCREEN_WIDTH);
            o_item.ax.addend = '0;
            o_item.ax.den    = FB_DEN_X;
            o_item.ay.mul_a  = COEF_W'(cx - RAWX_LO);
            o_item.ay.mul_b  = MULB_W'(SCREEN_HEIGHT);
            o_item.ay.addend = '0;
            o_item.ay.den    = FB_DEN_Y;
        end
    end

endmodule
`default_nettype wire

// File: design/tspm_fifo.sv
`default_nettype none
// ============================================================================
// tspm_fifo
// Short queue between the front and back ends.
// ============================================================================
module tspm_fifo import tspm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_item,
    input  wire logic  i_pop,
    output t_work      o_item,
    output t_fifo_stat o_stat
);

    t_work              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0]  r_wr_ptr;
    logic [FPTR_W-1:0]  r_rd_ptr;
    logic [FCNT_W-1:0]  r_count;
    logic [FCNT_W-1:0]  n_count;

    assign o_stat.full  = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + FCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - FCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FCNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: design/tspm_div.sv
`default_nettype none
// ============================================================================
// tspm_div
// Pipelined restoring divider, one quotient bit per stage, quotient
// saturated to all ones when it would not fit.
// ============================================================================
module tspm_div import tspm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_neg,
    input  wire logic [MAG_W-1:0] i_mag,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic                  o_neg,
    output logic [Q_W-1:0]        o_quot
);

    logic             r_vld  [Q_W+1];
    logic             r_neg  [Q_W+1];
    logic [Q_W-1:0]   r_quot [Q_W+1];
    logic             r_sat  [Q_W];
    logic [MAG_W-1:0] r_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [MAG_W-1:0] den_top;

    assign den_top = MAG_W'({i_den, {Q_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg[0]  <= i_neg;
        r_sat[0]  <= (i_mag >= den_top);
        r_rem[0]  <= i_mag;
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int K = Q_W - 1 - j;
        logic [MAG_W-1:0] sh;
        logic             ge;

        assign sh = MAG_W'(r_den[j]) << K;
        assign ge = (r_rem[j] >= sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_neg[j+1]  <= r_neg[j];
            r_quot[j+1] <= r_quot[j] | (Q_W'(r_sat[j] || ge) << K);
        end

        if (j < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_sat[j+1] <= r_sat[j];
                r_rem[j+1] <= ge ? (r_rem[j] - sh) : r_rem[j];
                r_den[j+1] <= r_den[j];
            end
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_neg   = r_neg[Q_W];
    assign o_quot  = r_quot[Q_W];

endmodule
`default_nettype wire

// File: design/tspm_back.sv
`default_nettype none
// ============================================================================
// tspm_back
// Multiply, add, divide, trim and clamp for both axes; registers the result.
// ============================================================================
module tspm_back import tspm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_fifo_stat i_fifo_stat,
    input  wire t_work      i_item,
    input  wire t_cfg       i_cfg,
    output logic            o_pop,
    output logic            o_strobe,
    output t_touch_result   o_result
);

    t_axis_op                 ops      [AX_N];
    logic                     r_m_vld;
    logic                     r_n_vld;
    logic                     r_a_vld;
    logic signed [NUM_W-1:0]  r_m_prod [AX_N];
    logic signed [COEF_W-1:0] r_m_add  [AX_N];
    logic [DEN_W-1:0]         r_m_den  [AX_N];
    logic signed [NUM_W-1:0]  r_n_num  [AX_N];
    logic [DEN_W-1:0]         r_n_den  [AX_N];
    logic [MAG_W-1:0]         r_a_mag  [AX_N];
    logic                     r_a_neg  [AX_N];
    logic [DEN_W-1:0]         r_a_den  [AX_N];
    logic                     div_vld  [AX_N];
    logic                     div_neg  [AX_N];
    logic [Q_W-1:0]           div_quot [AX_N];
    logic signed [OFS_W-1:0]  ofs      [AX_N];
    logic signed [SUM_W-1:0]  lim      [AX_N];
    logic signed [SUM_W-1:0]  pos      [AX_N];
    logic [PIX_W-1:0]         pix      [AX_N];
    t_side                    r_side   [SIDE_LEN];
    t_side                    side;
    logic                     r_strobe;
    t_touch_result            r_result;

    assign o_pop  = !i_fifo_stat.empty;
    assign ops[0] = i_item.ax;
    assign ops[1] = i_item.ay;
    assign ofs[0] = i_cfg.trim_x;
    assign ofs[1] = i_cfg.trim_y;
    assign lim[0] = SUM_W'(SCREEN_WIDTH);
    assign lim[1] = SUM_W'(SCREEN_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld  <= 1'b0;
            r_n_vld  <= 1'b0;
            r_a_vld  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_m_vld  <= o_pop;
            r_n_vld  <= r_m_vld;
            r_a_vld  <= r_n_vld;
            r_strobe <= div_vld[0] && div_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < AX_N; a++) begin
            r_m_prod[a] <= ops[a].mul_a * ops[a].mul_b;
            r_m_add[a]  <= ops[a].addend;
            r_m_den[a]  <= ops[a].den;
            r_n_num[a]  <= r_m_prod[a] + NUM_W'(r_m_add[a]);
            r_n_den[a]  <= r_m_den[a];
            r_a_neg[a]  <= r_n_num[a][NUM_W-1];
            r_a_mag[a]  <= r_n_num[a][NUM_W-1] ? MAG_W'(-r_n_num[a]) : MAG_W'(r_n_num[a]);
            r_a_den[a]  <= r_n_den[a];
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= '{touched: i_item.touched, pressure: i_item.pressure};
        for (int k = 1; k < SIDE_LEN; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    for (genvar a = 0; a < AX_N; a++) begin : g_axis
        tspm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_a_vld),
            .i_neg   (r_a_neg[a]),
            .i_mag   (r_a_mag[a]),
            .i_den   (r_a_den[a]),
            .o_valid (div_vld[a]),
            .o_neg   (div_neg[a]),
            .o_quot  (div_quot[a])
        );

        assign pos[a] = (div_neg[a] ? -SUM_W'(div_quot[a]) : SUM_W'(div_quot[a]))
                      + SUM_W'(ofs[a]);
        assign pix[a] = to_pixel(pos[a], lim[a]);
    end

    assign side = r_side[SIDE_LEN-1];

    always_ff @(posedge i_clk) begin
        if (side.touched) begin
            r_result <= '{touched: 1'b1, pixel_x: pix[0], pixel_y: pix[1],
                          pressure: side.pressure};
        end else begin
            r_result <= '0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: design/touch_sample_to_pixel_mapper.sv
`default_nettype none
// ============================================================================
// touch_sample_to_pixel_mapper
// Maps one resistive touch frame to a screen pixel and a pressure value.
// ============================================================================
// A frame is taken on any clock with start high and busy low, one frame per
// clock sustained. Its result appears on o_result with o_strobe high for one
// cycle, once the frame has passed the input queue, the product, sum and
// magnitude stages, the per-axis divider, one quotient bit per stage over
// 13 stages, and the output register; the result cannot be held off. busy
// is high in reset and otherwise only if the two-entry input queue is full,
// which the back end, draining one entry every cycle, never lets happen.
// Configuration writes complete at once (o_cfg_ready is always high) and
// must be made only while no frame is in flight.
module touch_sample_to_pixel_mapper import tspm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire t_touch_frame      i_frame,
    output logic                   busy,
    output logic                   o_strobe,
    output t_touch_result          o_result,
    input  wire logic              i_cfg_valid,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CDAT_W-1:0] i_cfg_data,
    output logic                   o_cfg_ready
);

    t_cfg       r_cfg;
    t_fifo_stat fifo_stat;
    t_work      push_item;
    t_work      pop_item;
    logic       push;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CAL_VALID: r_cfg.cal_valid <= i_cfg_data[0];
                CFG_ALPHA_X:   r_cfg.alpha_x   <= i_cfg_data[COEF_W-1:0];
                CFG_BETA_X:    r_cfg.beta_x    <= i_cfg_data[COEF_W-1:0];
                CFG_ALPHA_Y:   r_cfg.alpha_y   <= i_cfg_data[COEF_W-1:0];
                CFG_BETA_Y:    r_cfg.beta_y    <= i_cfg_data[COEF_W-1:0];
                CFG_DIVIDER:   r_cfg.divider   <= i_cfg_data[DEN_W-1:0];
                CFG_TRIM_X:    r_cfg.trim_x    <= i_cfg_data[OFS_W-1:0];
                CFG_TRIM_Y:    r_cfg.trim_y    <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    tspm_front u_front (
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_frame     (i_frame),
        .i_cfg       (r_cfg),
        .i_fifo_stat (fifo_stat),
        .o_busy      (busy),
        .o_push      (push),
        .o_item      (push_item)
    );

    tspm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (fifo_stat)
    );

    tspm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fifo_stat (fifo_stat),
        .i_item      (pop_item),
        .i_cfg       (r_cfg),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, RESULT_LAT))
        else $error("result without a matching accepted frame");

    a_untouched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.touched) |->
            (o_result.pixel_x == '0 && o_result.pixel_y == '0 && o_result.pressure == '0))
        else $error("untouched result carries nonzero fields");

    a_touched_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.touched) |-> (PRS_W'(o_result.pressure) >= PRESS_LIMIT))
        else $error("touched result below pressure threshold");

endmodule
`default_nettype wire

// File: tb/sv/touch_sample_to_pixel_mapper_tb.sv
// ============================================================================
// touch_sample_to_pixel_mapper_tb
// Self-checking bench for the touch frame to screen pixel mapper. A directed
// table covers pressure threshold, saturation, sample averaging, fallback
// clamps and affine extremes. Randomized phases follow, each with its own
// calibration setting, and are scored against an in-bench mapping model.
// ============================================================================
module touch_sample_to_pixel_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tspm_pkg::*;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 11;
    localparam int PHASES           = 10;
    localparam int FRAMES_PER_PHASE = 125;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SAMPLES          = 4;
    localparam int SMP_MAX          = (1 << SMP_W) - 1;
    localparam int PRESS_BIAS       = 1 << SMP_W;

    typedef struct {
        logic              is_cfg;
        logic [CIDX_W-1:0] idx;
        logic [CDAT_W-1:0] data;
        t_touch_frame      frame;
        logic              pinned;
        t_touch_result     want;
    } t_plan_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    t_touch_frame      i_frame     = '0;
    logic              i_cfg_valid = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CDAT_W-1:0] i_cfg_data  = '0;
    logic              busy;
    logic              o_strobe;
    t_touch_result     o_result;
    logic              o_cfg_ready;

    logic              pin_valid   = 1'b0;
    t_touch_result     pin_result  = '0;

    t_cfg              cal_shadow  = CFG_RESET;
    t_touch_result     pending_pixels[$];
    t_plan_row         plan[$];
    int                frames_sent   = 0;
    int                results_seen  = 0;
    int                mismatches    = 0;
    int                quiet_cycles  = 0;
    int                idle_pct_of[3] = '{0, 45, 21};

    touch_sample_to_pixel_mapper uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_frame     (i_frame),
        .busy        (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    function automatic t_touch_result map_touch_frame(input t_touch_frame f, input t_cfg c);
        t_touch_result r;
        int            press, rx, ry, cx, cy;
        longint        px, py, den;
        r = '0;
        press = int'(f.press_a) - int'(f.press_b) + PRESS_BIAS;
        if (press < int'(PRESS_LIMIT)) begin
            return r;
        end
        rx = (int'(f.x_sample_0) + int'(f.x_sample_1) + int'(f.x_sample_2)
              + int'(f.x_sample_3)) / SAMPLES;
        ry = (int'(f.y_sample_0) + int'(f.y_sample_1) + int'(f.y_sample_2)
              + int'(f.y_sample_3)) / SAMPLES;
        if (c.cal_valid) begin
            den = (c.divider == '0) ? 64'sd1 : longint'(c.divider);
            px = (longint'(c.alpha_x) * rx + longint'(c.beta_x)) / den;
            py = (longint'(c.alpha_y) * ry + longint'(c.beta_y)) / den;
        end else begin
            cx = (rx < int'(RAWX_LO)) ? int'(RAWX_LO) : (rx > int'(RAWX_HI)) ? int'(RAWX_HI) : rx;
            cy = (ry < int'(RAWY_LO)) ? int'(RAWY_LO) : (ry > int'(RAWY_HI)) ? int'(RAWY_HI) : ry;
            px = (cy - int'(RAWY_LO)) * SCREEN_WIDTH / (int'(RAWY_HI) - int'(RAWY_LO));
            py = (cx - int'(RAWX_LO)) * SCREEN_HEIGHT / (int'(RAWX_HI) - int'(RAWX_LO));
        end
        px += longint'(c.trim_x);
        py += longint'(c.trim_y);
        if (px < 0) begin
            px = 0;
        end else if (px >= SCREEN_WIDTH) begin
            px = SCREEN_WIDTH - 1;
        end
        if (py < 0) begin
            py = 0;
        end else if (py >= SCREEN_HEIGHT) begin
            py = SCREEN_HEIGHT - 1;
        end
        r.touched  = 1'b1;
        r.pixel_x  = px[PIX_W-1:0];
        r.pixel_y  = py[PIX_W-1:0];
        r.pressure = SMP_W'(press > int'(PRESS_MAX) ? int'(PRESS_MAX) : press);
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : score_results
        t_touch_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                results_seen++;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: result expected none actual %p", $time, o_result);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("touched", want.touched, o_result.touched);
                    check_field("pixel_x", want.pixel_x, o_result.pixel_x);
                    check_field("pixel_y", want.pixel_y, o_result.pixel_y);
                    check_field("pressure", want.pressure, o_result.pressure);
                end
            end
            if (start && !busy) begin
                pending_pixels.push_back(pin_valid ? pin_result
                                                   : map_touch_frame(i_frame, cal_shadow));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CAL_VALID: cal_shadow.cal_valid = i_cfg_data[0];
                    CFG_ALPHA_X:   cal_shadow.alpha_x   = i_cfg_data;
                    CFG_BETA_X:    cal_shadow.beta_x    = i_cfg_data;
                    CFG_ALPHA_Y:   cal_shadow.alpha_y   = i_cfg_data;
                    CFG_BETA_Y:    cal_shadow.beta_y    = i_cfg_data;
                    CFG_DIVIDER:   cal_shadow.divider   = i_cfg_data[DEN_W-1:0];
                    CFG_TRIM_X:    cal_shadow.trim_x    = i_cfg_data[OFS_W-1:0];
                    CFG_TRIM_Y:    cal_shadow.trim_y    = i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** touch_sample_to_pixel_mapper: FAILED **");
            $finish;
        end
    end

    task automatic issue_frame(input t_touch_frame f, input logic pin,
                               input t_touch_result pin_val);
        start      <= 1'b1;
        i_frame    <= f;
        pin_valid  <= pin;
        pin_result <= pin_val;
        do @(posedge i_clk); while (!(start && !busy));
        frames_sent++;
    endtask

    task automatic drain_frames();
        start <= 1'b0;
        while (results_seen < frames_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    function automatic int near_sample(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        return (v < 0) ? 0 : (v > SMP_MAX) ? SMP_MAX : v;
    endfunction

    function automatic t_touch_frame random_touch_frame();
        t_touch_frame f;
        int           sel, pa, pb, target, gap, xc, yc, spread;
        int           xs[SAMPLES], ys[SAMPLES];
        sel = $urandom_range(0, 99);
        gap = PRESS_BIAS - int'(PRESS_LIMIT);
        if (sel < 15) begin
            pa = $urandom_range(0, SMP_MAX - gap - 1);
            pb = $urandom_range(pa + gap + 1, SMP_MAX);
        end else if (sel < 25) begin
            target = $urandom_range(int'(PRESS_LIMIT) - 4, int'(PRESS_LIMIT) + 4);
            pa = $urandom_range(0, target - 1);
            pb = pa + PRESS_BIAS - target;
        end else begin
            pa = $urandom_range(0, SMP_MAX);
            pb = $urandom_range(0, SMP_MAX);
        end
        case ($urandom_range(0, 3))
            0:       xc = near_sample(int'(RAWX_LO), 3);
            1:       xc = near_sample(int'(RAWX_HI), 3);
            default: xc = $urandom_range(0, SMP_MAX);
        endcase
        case ($urandom_range(0, 3))
            0:       yc = near_sample(int'(RAWY_LO), 3);
            1:       yc = near_sample(int'(RAWY_HI), 3);
            default: yc = $urandom_range(0, SMP_MAX);
        endcase
        spread = ($urandom_range(0, 3) == 0) ? SMP_MAX : 6;
        foreach (xs[i]) begin
            xs[i] = near_sample(xc, spread);
            ys[i] = near_sample(yc, spread);
        end
        f.press_a    = SMP_W'(pa);
        f.press_b    = SMP_W'(pb);
        f.x_sample_0 = SMP_W'(xs[0]);
        f.x_sample_1 = SMP_W'(xs[1]);
        f.x_sample_2 = SMP_W'(xs[2]);
        f.x_sample_3 = SMP_W'(xs[3]);
        f.y_sample_0 = SMP_W'(ys[0]);
        f.y_sample_1 = SMP_W'(ys[1]);
        f.y_sample_2 = SMP_W'(ys[2]);
        f.y_sample_3 = SMP_W'(ys[3]);
        return f;
    endfunction

    function automatic logic [CDAT_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [CDAT_W-1:0] pick_offset(input int k);
        logic [CDAT_W-1:0] d;
        d = $urandom();
        case (k % 5)
            0:       d[OFS_W-1:0] = 8'h80;
            1:       d[OFS_W-1:0] = 8'h7F;
            2:       d[OFS_W-1:0] = OFS_W'(int'($urandom_range(0, 198)) - 99);
            3:       ;
            default: d[OFS_W-1:0] = '0;
        endcase
        return d;
    endfunction

    task automatic program_phase(input int p);
        int                mode, den, kx, ky;
        logic [CDAT_W-1:0] sel_word, gain_x, bias_x, gain_y, bias_y, div_word;
        logic [CIDX_W-1:0] stray;
        mode = p % 4;
        sel_word = $urandom();
        sel_word[0] = (mode != 0);
        case (mode)
            1: begin
                den    = $urandom_range(1, 65536);
                kx     = den / 8 + 1;
                ky     = den / 12 + 1;
                gain_x = int'($urandom_range(0, 2 * kx)) - kx;
                gain_y = int'($urandom_range(0, 2 * ky)) - ky;
                bias_x = den * (int'($urandom_range(0, 1100)) - 300);
                bias_y = den * (int'($urandom_range(0, 800)) - 250);
                div_word = den;
            end
            2: begin
                gain_x   = pick_extreme();
                bias_x   = pick_extreme();
                gain_y   = pick_extreme();
                bias_y   = pick_extreme();
                div_word = pick_extreme();
            end
            default: begin
                gain_x   = $urandom();
                bias_x   = $urandom();
                gain_y   = $urandom();
                bias_y   = $urandom();
                div_word = $urandom();
            end
        endcase
        stray = CIDX_W'($urandom_range((1 << CIDX_W) - 1, int'(CFG_TRIM_Y) + 1));
        write_reg(stray, $urandom());
        write_reg(CFG_CAL_VALID, sel_word);
        write_reg(CFG_ALPHA_X, gain_x);
        write_reg(CFG_BETA_X, bias_x);
        write_reg(CFG_ALPHA_Y, gain_y);
        write_reg(CFG_BETA_Y, bias_y);
        write_reg(CFG_DIVIDER, div_word);
        write_reg(CFG_TRIM_X, pick_offset(p));
        write_reg(CFG_TRIM_Y, pick_offset(p + 2));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_touch_frame flat_frame(input int pa, input int pb,
                                                input int x, input int y);
        return t_touch_frame'{SMP_W'(pa), SMP_W'(pb), SMP_W'(x), SMP_W'(x), SMP_W'(x),
                              SMP_W'(x), SMP_W'(y), SMP_W'(y), SMP_W'(y), SMP_W'(y)};
    endfunction

    function automatic t_plan_row frame_row(input t_touch_frame f, input logic pin,
                                            input t_touch_result want);
        t_plan_row r;
        r = '{is_cfg: 1'b0, idx: '0, data: '0, frame: f, pinned: pin, want: want};
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input logic [CIDX_W-1:0] idx,
                                          input logic [CDAT_W-1:0] data);
        t_plan_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, frame: '0, pinned: 1'b0, want: '0};
        return r;
    endfunction

    initial begin
        t_touch_result no_touch;
        no_touch = '0;

        // reset setting: fallback mapping, x trim +30
        plan.push_back(frame_row(flat_frame(0, SMP_MAX, 2048, 2048), 1'b1, no_touch));
        plan.push_back(frame_row(flat_frame(0, 3897, 1000, 1000), 1'b1, no_touch));
        plan.push_back(frame_row(flat_frame(0, 3896, 0, 0), 1'b1,
                                 t_touch_result'{1'b1, 9'd30, 9'd0, 12'd200}));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, SMP_MAX, SMP_MAX), 1'b1,
                                 t_touch_result'{1'b1, 9'd479, 9'd319, 12'd4095}));
        plan.push_back(frame_row(flat_frame(0, 1, 900, 900), 1'b0, no_touch));
        plan.push_back(frame_row(flat_frame(7, 7, 1500, 500), 1'b0, no_touch));
        plan.push_back(frame_row(t_touch_frame'{12'd4095, 12'd0, 12'd27, 12'd28, 12'd28,
                                                12'd28, 12'd301, 12'd300, 12'd300,
                                                12'd299}, 1'b0, no_touch));
        plan.push_back(frame_row(flat_frame(3000, 100, 1800, 2047), 1'b0, no_touch));
        plan.push_back(frame_row(flat_frame(3000, 100, 1801, 2048), 1'b0, no_touch));
        plan.push_back(frame_row(flat_frame(3000, 100, 29, 301), 1'b0, no_touch));
        plan.push_back(frame_row(flat_frame(12'hAAA, 12'h555, 12'h555, 12'hAAA), 1'b0,
                                 no_touch));
        plan.push_back(frame_row(flat_frame(12'h555, 12'hAAA, 12'hAAA, 12'h555), 1'b0,
                                 no_touch));
        // writes outside the register map must not alias onto real registers
        plan.push_back(cfg_row(CIDX_W'(int'(CFG_TRIM_Y) + 1), 32'h0000_0001));
        plan.push_back(cfg_row(CIDX_W'((1 << CIDX_W) - 1), 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_TRIM_X, 32'hABCD_EF80));
        plan.push_back(cfg_row(CFG_TRIM_Y, 32'h0000_007F));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, 1000, 1000), 1'b0, no_touch));
        // identity affine, divider zero acts as one
        plan.push_back(cfg_row(CFG_CAL_VALID, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_ALPHA_X, 32'd1));
        plan.push_back(cfg_row(CFG_BETA_X, 32'd0));
        plan.push_back(cfg_row(CFG_ALPHA_Y, 32'd1));
        plan.push_back(cfg_row(CFG_BETA_Y, 32'd0));
        plan.push_back(cfg_row(CFG_DIVIDER, 32'h8000_0000));
        plan.push_back(cfg_row(CFG_TRIM_X, 32'd0));
        plan.push_back(cfg_row(CFG_TRIM_Y, 32'd0));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, 100, 200), 1'b1,
                                 t_touch_result'{1'b1, 9'd100, 9'd200, 12'd4095}));
        plan.push_back(cfg_row(CFG_ALPHA_X, 32'h8000_0000));
        plan.push_back(cfg_row(CFG_BETA_X, 32'h8000_0000));
        plan.push_back(cfg_row(CFG_ALPHA_Y, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(CFG_BETA_Y, 32'h7FFF_FFFF));
        plan.push_back(cfg_row(CFG_DIVIDER, 32'hFFFF_FFFF));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, SMP_MAX, SMP_MAX), 1'b1,
                                 t_touch_result'{1'b1, 9'd0, 9'd319, 12'd4095}));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, 0, 0), 1'b0, no_touch));
        plan.push_back(cfg_row(CFG_DIVIDER, 32'd1));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, SMP_MAX, 1), 1'b0, no_touch));
        // negative quotient truncates toward zero
        plan.push_back(cfg_row(CFG_ALPHA_X, 32'hFFFF_FFF9));
        plan.push_back(cfg_row(CFG_BETA_X, 32'd0));
        plan.push_back(cfg_row(CFG_DIVIDER, 32'd4));
        plan.push_back(cfg_row(CFG_TRIM_X, 32'd10));
        plan.push_back(frame_row(flat_frame(SMP_MAX, 0, 1, 1), 1'b0, no_touch));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_frames();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (i_cfg_valid) begin
                    i_cfg_valid <= 1'b0;
                end
                issue_frame(plan[i].frame, plan[i].pinned, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_frames();
            program_phase(p);
            repeat (FRAMES_PER_PHASE) begin
                if (int'($urandom_range(0, 99)) < idle_pct_of[p % 3]) begin
                    start   <= 1'b0;
                    i_frame <= random_touch_frame();
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
                issue_frame(random_touch_frame(), 1'b0, no_touch);
            end
        end

        drain_frames();
        repeat (RESULT_LAT + 4) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: results expected %0d more actual none", $time,
                     pending_pixels.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("** touch_sample_to_pixel_mapper: PASSED **");
        end else begin
            $display("** touch_sample_to_pixel_mapper: FAILED **");
        end
        $finish;
    end

endmodule
